// File: rtl/core/svrd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time table builders for the sine voice.
// No dependencies; imported by the voice top level, the sine ROM and the checker.
package svrd_pkg;

   localparam int DEF_SAMPLE_RATE_HZ  = 48000;
   localparam int DEF_SINE_TABLE_BITS = 10;
   localparam int DEF_PHASE_BITS      = 32;

   // Field widths
   localparam int FUNC_W    = 2;
   localparam int NOTE_W    = 7;
   localparam int VEL_W     = 7;
   localparam int REQ_DW    = 16;
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int TAIL_W    = 17;
   localparam int SINE_W    = 15;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_NOTES = 1 << NOTE_W;

   // Shared multiplier
   localparam int MUL_W     = 24;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int GAIN_FRAC = 16;

   // x / 127 == (x * RECIP_127) >> RECIP_SHIFT for every x below 127 * 2^16
   localparam logic [MUL_W-1:0] RECIP_127   = 24'd8454661;
   localparam int               RECIP_SHIFT = 30;

   localparam logic [TAIL_W-1:0] TAIL_UNITY = 17'h10000;

   localparam logic [GAIN_W-1:0] LEVEL_SCALE_RST   = 16'd9830;
   localparam logic [GAIN_W-1:0] DECAY_FACTOR_RST  = 16'd64881;
   localparam logic [GAIN_W-1:0] END_THRESHOLD_RST = 16'd328;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_NOTE_ON  = 2'd1,
      FUNC_NOTE_OFF = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_SCALE   = 2'd0,
      CSR_DECAY_FACTOR  = 2'd1,
      CSR_END_THRESHOLD = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LVL_DIV,
      ST_LVL_WB,
      ST_MUL_LEVEL,
      ST_MUL_TAIL,
      ST_MUL_DECAY,
      ST_EMIT
   } state_type;

   // Quarter-wave sine entry, Q0.15, fifteenth-order Taylor series in Q30.
   function automatic logic [SINE_W-1:0] sine_entry(input int i, input int tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (64'd1686629713 * 64'(i)) >> tbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = (sum >= term) ? sum - term : 64'd0;
      v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      return (v > 64'd32767) ? 15'h7fff : v[SINE_W-1:0];
   endfunction

   // Phase step of a MIDI note: octave-4 frequency (1e-7 Hz units) scaled by
   // 2^(octave + pbits), divided by 32 * rate * 1e7 with a restoring divider.
   function automatic logic [63:0] note_step(input int note, input int pbits,
                                             input int srate);
      logic [63:0] f;
      logic [63:0] d;
      logic [63:0] r;
      logic [63:0] q;
      logic        bit_v;
      int          oct;
      int          s;
      int          j;
      oct = note / 12;
      case (note % 12)
         0:       f = 64'd2616255653;
         1:       f = 64'd2771826310;
         2:       f = 64'd2936647679;
         3:       f = 64'd3111269837;
         4:       f = 64'd3296275569;
         5:       f = 64'd3492282314;
         6:       f = 64'd3699944227;
         7:       f = 64'd3919954360;
         8:       f = 64'd4153046976;
         9:       f = 64'd4400000000;
         10:      f = 64'd4661637615;
         default: f = 64'd4938833013;
      endcase
      s = oct + pbits;
      d = 64'd32 * 64'(srate) * 64'd10000000;
      r = '0;
      q = '0;
      for (j = 127; j >= 0; j--) begin
         bit_v = 1'b0;
         if (j >= s && (j - s) < 64) begin
            bit_v = f[j - s];
         end
         r = {r[62:0], bit_v};
         q = {q[62:0], 1'b0};
         if (r >= d) begin
            r    = r - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

// File: rtl/core/svrd_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine ROM with registered read, contents built at elaboration.
// Depends on svrd_pkg (sine_entry, SINE_W).
module svrd_sine_rom #(
   parameter int SINE_TABLE_BITS = svrd_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [SINE_TABLE_BITS:0]      rd_addr,
   output logic [svrd_pkg::SINE_W-1:0]   rd_data_ff
);
   import svrd_pkg::*;

   localparam int QUARTER = 1 << SINE_TABLE_BITS;

   logic [SINE_W-1:0] rom_table [0:QUARTER];

   for (genvar i = 0; i <= QUARTER; i++) begin : g_entry
      localparam logic [SINE_W-1:0] ENTRY = sine_entry(i, SINE_TABLE_BITS);
      assign rom_table[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_table[rd_addr];
      end
   end

endmodule

// File: rtl/core/sine_voice_with_release_decay_unit.sv
`timescale 1ns / 1ps
// Single DDS sine voice with exponential release: sequencer, voice state, shared multiplier.
// Depends on svrd_pkg and svrd_sine_rom.

// One item is taken at a time. A sample tick on a sounding voice runs through the
// transaction, three passes through the one 24x24 multiplier for sine x level,
// x tail and tail x decay, then the result load; a tick on an idle voice goes from
// the transaction straight to the result load, a note-on does velocity x scale, then
// the reciprocal multiply for /127 and the level write-back, and a note-off or the
// unused func code only the transaction. The result sits in an output register, so
// the next item is taken while it waits; a tick only stalls in its result load if the
// previous result has not been taken yet. Configuration writes are taken in any cycle.
module sine_voice_with_release_decay_unit #(
   parameter int SAMPLE_RATE_HZ  = svrd_pkg::DEF_SAMPLE_RATE_HZ,
   parameter int SINE_TABLE_BITS = svrd_pkg::DEF_SINE_TABLE_BITS,
   parameter int PHASE_BITS      = svrd_pkg::DEF_PHASE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [svrd_pkg::REQ_DW-1:0]      req_tdata,   // note[6:0], velocity[13:7], zero
   input  logic [svrd_pkg::FUNC_W-1:0]      req_tuser,   // func[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [svrd_pkg::SAMPLE_W-1:0]    rsp_tdata,   // sample[15:0]
   output logic                             rsp_tuser,   // active[0]
   output logic                             rsp_tlast,   // ended
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [svrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [svrd_pkg::GAIN_W-1:0]      csr_data
);
   import svrd_pkg::*;

   localparam int QUARTER = 1 << SINE_TABLE_BITS;
   localparam int ADDR_W  = SINE_TABLE_BITS + 1;
   localparam int TOP_W   = SINE_TABLE_BITS + 2;

   // Note phase-step table
   logic [PHASE_BITS-1:0] step_table [0:NUM_NOTES-1];

   for (genvar n = 0; n < NUM_NOTES; n++) begin : g_step
      localparam logic [63:0] STEP = note_step(n, PHASE_BITS, SAMPLE_RATE_HZ);
      assign step_table[n] = STEP[PHASE_BITS-1:0];
   end

   state_type             state_ff, state_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [GAIN_W-1:0]     level_ff, level_in;
   logic [TAIL_W-1:0]     tail_ff, tail_in;
   logic                  releasing_ff, releasing_in;
   logic                  sounding_ff, sounding_in;
   logic [GAIN_W-1:0]     scale_ff, scale_in;
   logic [GAIN_W-1:0]     decay_ff, decay_in;
   logic [GAIN_W-1:0]     thresh_ff, thresh_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [SINE_W-1:0]     mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                  rsp_active_ff, rsp_active_in;
   logic                  rsp_ended_ff, rsp_ended_in;

   logic                  req_accept;
   logic                  emit_go;
   func_type              func;
   logic [NOTE_W-1:0]     note;
   logic [VEL_W-1:0]      velocity;
   logic [TOP_W-1:0]      phase_top;
   logic [ADDR_W-1:0]     rom_addr;
   logic [SINE_W-1:0]     rom_data;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [TAIL_W-1:0]     tail_next;
   logic                  stop;

   assign func     = func_type'(req_tuser);
   assign note     = req_tdata[NOTE_W-1:0];
   assign velocity = req_tdata[NOTE_W +: VEL_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // Quadrant fold: odd quadrants read the table mirrored
   assign phase_top = phase_ff[PHASE_BITS-1 -: TOP_W];
   assign rom_addr  = phase_top[TOP_W-2] ?
                      (ADDR_W'(QUARTER) - {1'b0, phase_top[SINE_TABLE_BITS-1:0]}) :
                      {1'b0, phase_top[SINE_TABLE_BITS-1:0]};

   svrd_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock      (clock),
      .rd_en      (req_accept),
      .rd_addr    (rom_addr),
      .rd_data_ff (rom_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (func)
                  FUNC_NOTE_ON: state_in = ST_LVL_DIV;
                  FUNC_TICK:    state_in = sounding_ff ? ST_MUL_LEVEL : ST_EMIT;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_LVL_DIV:   state_in = ST_LVL_WB;
         ST_LVL_WB:    state_in = ST_IDLE;
         ST_MUL_LEVEL: state_in = ST_MUL_TAIL;
         ST_MUL_TAIL:  state_in = ST_MUL_DECAY;
         ST_MUL_DECAY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = MUL_W'(velocity);
            mul_b = MUL_W'(scale_ff);
         end
         ST_LVL_DIV: begin
            mul_a = MUL_W'(prod_ff[VEL_W+GAIN_W-1:0]);
            mul_b = RECIP_127;
         end
         ST_MUL_LEVEL: begin
            mul_a = MUL_W'(rom_data);
            mul_b = MUL_W'(level_ff);
         end
         ST_MUL_TAIL: begin
            // unity tail while held keeps the magnitude unchanged
            mul_a = MUL_W'(prod_ff[SINE_W+GAIN_FRAC-1:GAIN_FRAC]);
            mul_b = releasing_ff ? MUL_W'(tail_ff) : MUL_W'(TAIL_UNITY);
         end
         ST_MUL_DECAY: begin
            mul_a = MUL_W'(tail_ff);
            mul_b = MUL_W'(decay_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in   = (state_ff == ST_EMIT) ? prod_ff : mul_a * mul_b;
   assign tail_next = prod_ff[TAIL_W+GAIN_FRAC-1:GAIN_FRAC];
   assign stop      = sounding_ff && releasing_ff && (tail_next <= TAIL_W'(thresh_ff));

   // Voice state, configuration and result register
   always_comb begin
      phase_in      = phase_ff;
      step_in       = step_ff;
      level_in      = level_ff;
      tail_in       = tail_ff;
      releasing_in  = releasing_ff;
      sounding_in   = sounding_ff;
      scale_in      = scale_ff;
      decay_in      = decay_ff;
      thresh_in     = thresh_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_active_in = rsp_active_ff;
      rsp_ended_in  = rsp_ended_ff;

      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_LEVEL_SCALE:   scale_in  = csr_data;
            CSR_DECAY_FACTOR:  decay_in  = csr_data;
            CSR_END_THRESHOLD: thresh_in = csr_data;
            default:           ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (func)
                  FUNC_NOTE_ON: begin
                     phase_in     = '0;
                     step_in      = step_table[note];
                     tail_in      = '0;
                     releasing_in = 1'b0;
                     sounding_in  = 1'b1;
                  end
                  FUNC_NOTE_OFF: begin
                     if (sounding_ff && !releasing_ff) begin
                        releasing_in = 1'b1;
                        tail_in      = TAIL_UNITY;
                     end
                  end
                  FUNC_TICK: begin
                     neg_in = sounding_ff & phase_top[TOP_W-1];
                     if (!sounding_ff) begin
                        mag_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LVL_WB: begin
            level_in = prod_ff[RECIP_SHIFT+GAIN_W-1:RECIP_SHIFT];
         end
         ST_MUL_LEVEL: begin
            phase_in = phase_ff + step_ff;
         end
         ST_MUL_DECAY: begin
            mag_in = prod_ff[SINE_W+GAIN_FRAC-1:GAIN_FRAC];
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (sounding_ff && releasing_ff) begin
                  tail_in = tail_next;
               end
               if (stop) begin
                  sounding_in  = 1'b0;
                  releasing_in = 1'b0;
               end
               rsp_valid_in  = 1'b1;
               rsp_data_in   = neg_ff ? (SAMPLE_W'(0) - SAMPLE_W'(mag_ff)) : SAMPLE_W'(mag_ff);
               rsp_active_in = sounding_ff & ~stop;
               rsp_ended_in  = stop;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         level_ff     <= '0;
         tail_ff      <= '0;
         releasing_ff <= 1'b0;
         sounding_ff  <= 1'b0;
         scale_ff     <= LEVEL_SCALE_RST;
         decay_ff     <= DECAY_FACTOR_RST;
         thresh_ff    <= END_THRESHOLD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         tail_ff      <= tail_in;
         releasing_ff <= releasing_in;
         sounding_ff  <= sounding_in;
         scale_ff     <= scale_in;
         decay_ff     <= decay_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_active_ff <= rsp_active_in;
      rsp_ended_ff  <= rsp_ended_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_active_ff;
   assign rsp_tlast  = rsp_ended_ff;

endmodule

// File: rtl/core/svrd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sine voice, bound to the top level.
// Depends on svrd_pkg and sine_voice_with_release_decay_unit.
module svrd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [svrd_pkg::FUNC_W-1:0]      req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [svrd_pkg::SAMPLE_W-1:0]    rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);
   import svrd_pkg::*;

   // A voice that ends on this tick is no longer active
   a_ended_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("ended result still marked active");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Ticks and note-ons occupy the sequencer past the accepting cycle
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_TICK || req_tuser == FUNC_NOTE_ON)
      |=> !req_tready)
      else $error("input taken while sequencer busy");

   // A new result only appears out of sequencer work, never from the idle state
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a transaction in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sine_voice_with_release_decay_unit svrd_checker u_svrd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
